// ----- src/bcpr_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpr_pkg
// shared widths and controller/datapath interface types for the pascal row
// binomial coefficient engine
// ----------------------------------------------------------------------------
package bcpr_pkg;

  localparam int VAL_W  = 6;
  localparam int COEF_W = 32;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_step;
    logic row_begin;
    logic rd;
    logic wr;
    logic row_end;
    logic fetch;
    logic put;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_bad;
    logic clear_done;
    logic rows_done;
    logic col_done;
  } sts_t;

endpackage

// ----- src/bcpr_dpath.sv -----
// ----------------------------------------------------------------------------
// bcpr_dpath
// row store, loop counters and adder for the pascal row sweep
// ----------------------------------------------------------------------------
module bcpr_dpath #(
  parameter int MAX_N = 32
) (
  input  logic                       clk,
  input  bcpr_pkg::cmd_t             cmd,
  input  logic [bcpr_pkg::VAL_W-1:0] in_n_value,
  input  logic [bcpr_pkg::VAL_W-1:0] in_k_value,
  output bcpr_pkg::sts_t             sts,
  output logic [bcpr_pkg::COEF_W-1:0] out_coefficient
);

  localparam int DEPTH = MAX_N + 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [bcpr_pkg::VAL_W-1:0] MAX_V = bcpr_pkg::VAL_W'(MAX_N);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_N);

  logic [bcpr_pkg::COEF_W-1:0] row_mem [DEPTH];

  logic [bcpr_pkg::VAL_W-1:0]  n_r;
  logic [bcpr_pkg::VAL_W-1:0]  k_r;
  logic [bcpr_pkg::VAL_W-1:0]  i_r;
  logic [IDX_W-1:0]            j_r;
  logic [IDX_W-1:0]            clr_r;
  logic [bcpr_pkg::COEF_W-1:0] rd_a_r;
  logic [bcpr_pkg::COEF_W-1:0] rd_b_r;
  logic [bcpr_pkg::COEF_W-1:0] coef_r;

  logic [bcpr_pkg::VAL_W-1:0]  top;
  logic [IDX_W-1:0]            k_idx;
  logic                        mem_we;
  logic [IDX_W-1:0]            wr_addr;
  logic [bcpr_pkg::COEF_W-1:0] wr_data;
  logic                        mem_re;
  logic [IDX_W-1:0]            rd_addr_a;
  logic [IDX_W-1:0]            rd_addr_b;

  assign top       = (i_r < k_r) ? i_r : k_r;
  assign k_idx     = k_r[IDX_W-1:0];

  assign sts.range_bad  = (n_r > MAX_V) || (k_r > MAX_V);
  assign sts.clear_done = (clr_r == LAST_IDX);
  assign sts.rows_done  = (i_r > n_r);
  assign sts.col_done   = (j_r == '0);

  assign mem_we    = cmd.clear_step || cmd.wr;
  assign wr_addr   = cmd.clear_step ? clr_r : j_r;
  assign wr_data   = cmd.clear_step ? ((clr_r == '0) ? bcpr_pkg::COEF_W'(1) : '0)
                                    : rd_a_r + rd_b_r;
  assign mem_re    = cmd.rd || cmd.fetch;
  assign rd_addr_a = cmd.fetch ? k_idx : j_r;
  assign rd_addr_b = j_r - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_a_r <= row_mem[rd_addr_a];
    end
    if (cmd.rd) begin
      rd_b_r <= row_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= in_n_value;
      k_r   <= in_k_value;
      i_r   <= bcpr_pkg::VAL_W'(1);
      clr_r <= '0;
    end
    if (cmd.clear_step) begin
      clr_r <= clr_r + IDX_W'(1);
    end
    if (cmd.row_begin) begin
      j_r <= top[IDX_W-1:0];
    end else if (cmd.wr) begin
      j_r <= j_r - IDX_W'(1);
    end
    if (cmd.row_end) begin
      i_r <= i_r + bcpr_pkg::VAL_W'(1);
    end
    if (cmd.put) begin
      coef_r <= sts.range_bad ? '0 : rd_a_r;
    end
  end

  assign out_coefficient = coef_r;

endmodule

// ----- src/bcpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcpr_ctrl
// sequencer for clear, row sweep and result of one request
// ----------------------------------------------------------------------------
module bcpr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bcpr_pkg::sts_t sts,
  output bcpr_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_ROW,
    S_TEST,
    S_READ,
    S_WRITE,
    S_FETCH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   put_r;
  logic   done_r;

  assign busy      = (state_r != S_IDLE) || put_r;
  assign out_valid = done_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.range_bad ? S_IDLE : S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (sts.rows_done) begin
          state_nxt = S_FETCH;
        end else begin
          cmd.row_begin = 1'b1;
          state_nxt     = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.col_done) begin
          cmd.row_end = 1'b1;
          state_nxt   = S_ROW;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_TEST;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.put = put_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      put_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      put_r   <= (state_r == S_FETCH) || ((state_r == S_CHECK) && sts.range_bad);
      done_r  <= put_r;
    end
  end

  // one result beat per request
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_wr_col: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !sts.col_done)
    else $error("row update issued at column zero");

  a_fetch_put: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |=> cmd.put ##1 out_valid)
    else $error("fetch not followed by result");

endmodule

// ----- src/binomial_coefficient_pascal_row.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_pascal_row
// returns C(n,k) by building one row of pascal's triangle in a row store,
// additions only
//
//   channel   ports                                   handshake
//   request   in_n_value, in_k_value                  start & !busy
//   result    out_coefficient                         out_valid, one cycle
//
// each read-add-write update passes through the column test with read, the
// registered read data and the write back, after a one-entry-a-cycle clear
// of all MAX_N+1 entries at the start of each in-range request. n or k above
// MAX_N skips the work and returns 0. rst_n is synchronous; the row store is
// not reset and is cleared per in-range request.
// the receiver cannot stall: the result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module binomial_coefficient_pascal_row #(
  parameter int MAX_N = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bcpr_pkg::VAL_W-1:0]  in_n_value,
  input  logic [bcpr_pkg::VAL_W-1:0]  in_k_value,
  output logic                        out_valid,
  output logic [bcpr_pkg::COEF_W-1:0] out_coefficient
);

  bcpr_pkg::cmd_t cmd;
  bcpr_pkg::sts_t sts;

  bcpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bcpr_dpath #(
    .MAX_N (MAX_N)
  ) u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .in_n_value      (in_n_value),
    .in_k_value      (in_k_value),
    .sts             (sts),
    .out_coefficient (out_coefficient)
  );

endmodule

// ----- dv/tb_binomial_coefficient_pascal_row.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient_pascal_row
// self-checking bench for the pascal row binomial coefficient engine: a short
// table of corner requests, then random requests, mostly small rows and a few
// full rows plus out-of-range noise, each result compared with a typed
// coefficient or a local pascal-row calculation
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_pascal_row;

  localparam int VAL_W         = bcpr_pkg::VAL_W;
  localparam int COEF_W        = bcpr_pkg::COEF_W;
  localparam int MAX_N         = 32;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_COUNT  = 515;
  localparam int CALM_COUNT    = 60;
  localparam int TAIL_CYCLES   = 24;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DIRECTED_COUNT = 25;

  typedef struct packed {
    logic [VAL_W-1:0]  n;
    logic [VAL_W-1:0]  k;
    logic              typed;
    logic [COEF_W-1:0] coef;
  } directed_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  n;
    logic [VAL_W-1:0]  k;
    logic [COEF_W-1:0] coef;
  } coef_beat_t;

  // typed coefficients only where obvious; untyped rows are checked by row build
  localparam directed_req_t DIRECTED_REQS [DIRECTED_COUNT] = '{
    '{n: 6'd0,  k: 6'd0,  typed: 1'b1, coef: 32'd1},
    '{n: 6'd0,  k: 6'd1,  typed: 1'b1, coef: 32'd0},
    '{n: 6'd1,  k: 6'd0,  typed: 1'b1, coef: 32'd1},
    '{n: 6'd1,  k: 6'd1,  typed: 1'b1, coef: 32'd1},
    '{n: 6'd32, k: 6'd0,  typed: 1'b1, coef: 32'd1},
    '{n: 6'd32, k: 6'd32, typed: 1'b1, coef: 32'd1},
    '{n: 6'd32, k: 6'd1,  typed: 1'b1, coef: 32'd32},
    '{n: 6'd32, k: 6'd31, typed: 1'b1, coef: 32'd32},
    '{n: 6'd32, k: 6'd16, typed: 1'b1, coef: 32'd601080390},
    '{n: 6'd31, k: 6'd32, typed: 1'b1, coef: 32'd0},
    '{n: 6'd33, k: 6'd0,  typed: 1'b1, coef: 32'd0},
    '{n: 6'd0,  k: 6'd33, typed: 1'b1, coef: 32'd0},
    '{n: 6'd63, k: 6'd63, typed: 1'b1, coef: 32'd0},
    '{n: 6'd32, k: 6'd33, typed: 1'b1, coef: 32'd0},
    '{n: 6'd63, k: 6'd0,  typed: 1'b1, coef: 32'd0},
    '{n: 6'd5,  k: 6'd2,  typed: 1'b0, coef: 32'd0},
    '{n: 6'd10, k: 6'd5,  typed: 1'b0, coef: 32'd0},
    '{n: 6'd20, k: 6'd7,  typed: 1'b0, coef: 32'd0},
    '{n: 6'd31, k: 6'd15, typed: 1'b0, coef: 32'd0},
    '{n: 6'd7,  k: 6'd7,  typed: 1'b1, coef: 32'd1},
    '{n: 6'd12, k: 6'd13, typed: 1'b1, coef: 32'd0},
    '{n: 6'd16, k: 6'd8,  typed: 1'b0, coef: 32'd0},
    '{n: 6'd2,  k: 6'd1,  typed: 1'b1, coef: 32'd2},
    '{n: 6'd42, k: 6'd21, typed: 1'b1, coef: 32'd0},
    '{n: 6'd21, k: 6'd42, typed: 1'b1, coef: 32'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [VAL_W-1:0]  in_n_value = '0;
  logic [VAL_W-1:0]  in_k_value = '0;
  logic              out_valid;
  logic [COEF_W-1:0] out_coefficient;

  logic [COEF_W-1:0] pascal_row [0:MAX_N];
  coef_beat_t        pending_coefs [$];
  int                cycle_count = 0;
  int                error_count = 0;
  int                request_count = 0;
  int                range_bad_count = 0;
  int                k_above_n_count = 0;
  int                full_row_count = 0;
  int                result_count = 0;

  binomial_coefficient_pascal_row #(
    .MAX_N(MAX_N)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_n_value     (in_n_value),
    .in_k_value     (in_k_value),
    .out_valid      (out_valid),
    .out_coefficient(out_coefficient)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // builds row n of pascal's triangle up to column k, additions only
  function automatic logic [COEF_W-1:0] pascal_coef(input logic [VAL_W-1:0] n,
                                                    input logic [VAL_W-1:0] k);
    int top;
    if (n > MAX_N || k > MAX_N) begin
      return '0;
    end
    for (int j = 0; j <= MAX_N; j++) begin
      pascal_row[j] = '0;
    end
    pascal_row[0] = COEF_W'(1);
    for (int i = 1; i <= n; i++) begin
      top = (i < k) ? i : k;
      for (int j = top; j > 0; j--) begin
        pascal_row[j] = pascal_row[j] + pascal_row[j-1];
      end
    end
    return pascal_row[k];
  endfunction

  task automatic issue_request(input logic [VAL_W-1:0] n, input logic [VAL_W-1:0] k,
                               input logic typed, input logic [COEF_W-1:0] coef);
    coef_beat_t        beat;
    logic [COEF_W-1:0] predicted;
    start      <= 1'b1;
    in_n_value <= n;
    in_k_value <= k;
    do @(posedge clk); while (busy);
    predicted = pascal_coef(n, k);
    beat.n    = n;
    beat.k    = k;
    beat.coef = typed ? coef : predicted;
    pending_coefs.push_back(beat);
    request_count++;
    if (n > MAX_N || k > MAX_N) begin
      range_bad_count++;
    end else if (k > n) begin
      k_above_n_count++;
    end
    if (n >= MAX_N - 1) begin
      full_row_count++;
    end
  endtask

  task automatic idle_burst(input int odds);
    if ($urandom_range(0, 2) < odds) begin
      start      <= 1'b0;
      in_n_value <= VAL_W'($urandom);
      in_k_value <= VAL_W'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    coef_beat_t head;
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_coefs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none, actual %0d", $time,
                 out_coefficient);
      end else begin
        head = pending_coefs.pop_front();
        if (out_coefficient !== head.coef) begin
          error_count++;
          $display("%0t: C(%0d,%0d) mismatch, expected %0d, actual %0d", $time,
                   head.n, head.k, head.coef, out_coefficient);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_coefs.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int               odds;
    int               pick;
    logic [VAL_W-1:0] n_pick;
    logic [VAL_W-1:0] k_pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    odds = 1;
    for (int idx = 0; idx < DIRECTED_COUNT; idx++) begin
      issue_request(DIRECTED_REQS[idx].n, DIRECTED_REQS[idx].k,
                    DIRECTED_REQS[idx].typed, DIRECTED_REQS[idx].coef);
      idle_burst(odds);
    end

    for (int idx = 0; idx < RANDOM_COUNT; idx++) begin
      if (idx % 32 == 0) begin
        odds = $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // small rows keep the run short
        n_pick = VAL_W'($urandom_range(0, 12));
        k_pick = VAL_W'($urandom_range(0, n_pick + 1));
      end else if (pick < 80) begin
        n_pick = VAL_W'($urandom_range(0, MAX_N));
        k_pick = VAL_W'($urandom_range(0, MAX_N));
      end else if (pick < 88) begin
        n_pick = VAL_W'($urandom_range(MAX_N - 1, MAX_N));
        k_pick = VAL_W'($urandom_range(0, MAX_N));
      end else begin
        n_pick = VAL_W'($urandom);
        k_pick = VAL_W'($urandom);
      end
      issue_request(n_pick, k_pick, 1'b0, '0);
      idle_burst((idx < RANDOM_COUNT - CALM_COUNT) ? odds : 0);
    end

    start <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests (%0d out of range, %0d with k above n, %0d near full rows)",
             request_count, range_bad_count, k_above_n_count, full_row_count);
    $display("%0d coefficients checked over %0d cycles, %0d errors",
             result_count, cycle_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bcpr_pkg.sv
src/bcpr_dpath.sv
src/bcpr_ctrl.sv
src/binomial_coefficient_pascal_row.sv
dv/tb_binomial_coefficient_pascal_row.sv
